// ----- design/lehdp_pkg.sv -----
// Shared types and constants of the Lehmer digit to permutation decoder.
package lehdp_pkg;

  localparam int unsigned DigitW    = 8;
  localparam int unsigned ElemW     = 9;
  localparam int unsigned ElemCntW  = 9;

  localparam logic [ElemCntW-1:0] ElemCountReset = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DESC = 4'b0010,
    ST_REM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctrl_t;

endpackage

// ----- design/lehdp_if.sv -----
// Request and response channel interfaces of the Lehmer digit decoder.
interface lehdp_req_if;
  logic                              valid;
  logic                              ready;
  logic [lehdp_pkg::DigitW-1:0]      digit;
  logic                              start_req;

  modport source (output valid, output digit, output start_req, input ready);
  modport sink   (input valid, input digit, input start_req, output ready);
endinterface

interface lehdp_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [lehdp_pkg::ElemW-1:0]       element;
  logic                              out_of_range;

  modport source (output valid, output element, output out_of_range, input ready);
  modport sink   (input valid, input element, input out_of_range, output ready);
endinterface

// ----- design/lehdp_cnt_mem.sv -----
// Fenwick count memory with one read and one write port and per-entry valid bits.
module lehdp_cnt_mem #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lehdp_pkg::mem_ctrl_t                  ctrl_i,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     raddr_i,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     waddr_i,
  input  logic [$clog2(MAX_ELEMENTS+1):0]       wdata_i,
  output logic [$clog2(MAX_ELEMENTS+1):0]       rdata_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [IW-1:0] One = IW'(1);

  logic [IW:0]           mem_q [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS:0] valid_q;
  logic [IW:0]           rdata_q;
  logic [IW-1:0]         raddr_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
      raddr_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvld_q <= valid_q[raddr_i] && !ctrl_i.clear;
      end
    end
  end

  // An entry never written since the last restore holds the lowest set bit of its index.
  assign rdata_o = rvld_q ? rdata_q : {1'b0, raddr_q & (~raddr_q + One)};

endmodule

// ----- design/lehdp_ctrl.sv -----
// Sequencer for the tree descent and the removal walk over the count memory.
module lehdp_ctrl #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [lehdp_pkg::ElemCntW-1:0]        elem_count_i,
  lehdp_req_if.sink                             req_i,
  lehdp_rsp_if.source                           rsp_o,
  output lehdp_pkg::mem_ctrl_t                  mem_ctrl_o,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]     raddr_o,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]     waddr_o,
  output logic [$clog2(MAX_ELEMENTS+1):0]       wdata_o,
  input  logic [$clog2(MAX_ELEMENTS+1):0]       rdata_i
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [IW-1:0] One = IW'(1);
  localparam logic [IW:0]   OneW = (IW+1)'(1);

  lehdp_pkg::state_e state_q, state_d;

  logic [lehdp_pkg::DigitW-1:0] k_q, k_d;
  logic [IW-1:0]                n_q, n_d;
  logic [IW-1:0]                pos_q, pos_d;
  logic [IW-1:0]                step_q, step_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic                         pend_q, pend_d;
  logic [lehdp_pkg::ElemW-1:0]  res_q, res_d;
  logic                         err_q, err_d;

  logic                         out_valid_q;
  logic [lehdp_pkg::ElemW-1:0]  out_elem_q;
  logic                         out_err_q;

  logic [IW-1:0]                n_eff;
  logic [IW-1:0]                top;
  logic                         ent_neg;
  logic [IW-1:0]                ent_val;
  logic                         take;
  logic [IW-1:0]                pos_nx;
  logic [lehdp_pkg::DigitW-1:0] k_nx;
  logic [IW-1:0]                step_nx;
  logic [IW:0]                  probe;
  logic                         probe_ok;
  logic [IW:0]                  elem;
  logic [IW-1:0]                lb;
  logic [IW:0]                  idx_nx;
  logic                         idx_ok;
  logic                         load;

  always_comb begin
    if (elem_count_i == '0) begin
      n_eff = One;
    end else if (32'(elem_count_i) > MAX_ELEMENTS) begin
      n_eff = IW'(MAX_ELEMENTS);
    end else begin
      n_eff = IW'(elem_count_i);
    end
  end

  always_comb begin
    top = One;
    for (int i = 0; i < IW; i++) begin
      if (n_eff[i]) begin
        top = One << i;
      end
    end
  end

  assign ent_neg  = rdata_i[IW];
  assign ent_val  = rdata_i[IW-1:0];
  assign take     = pend_q && !ent_neg && (32'(ent_val) <= 32'(k_q));
  assign pos_nx   = take ? (pos_q + step_q) : pos_q;
  assign k_nx     = take ? (k_q - lehdp_pkg::DigitW'(ent_val)) : k_q;
  assign step_nx  = step_q >> 1;
  assign probe    = {1'b0, pos_nx} + {1'b0, step_nx};
  assign probe_ok = probe <= {1'b0, n_q};
  assign elem     = {1'b0, pos_nx} + OneW;

  assign lb       = idx_q & (~idx_q + One);
  assign idx_nx   = {1'b0, idx_q} + {1'b0, lb};
  assign idx_ok   = idx_nx <= {1'b0, n_q};

  // Once a count has wrapped below zero it stays larger than any digit.
  always_comb begin
    if (ent_neg) begin
      wdata_o = rdata_i;
    end else if (ent_val == '0) begin
      wdata_o = {1'b1, {IW{1'b0}}};
    end else begin
      wdata_o = {1'b0, ent_val - One};
    end
  end

  assign load = (state_q == lehdp_pkg::ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    n_d        = n_q;
    pos_d      = pos_q;
    step_d     = step_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    res_d      = res_q;
    err_d      = err_q;
    mem_ctrl_o = '0;
    raddr_o    = '0;
    waddr_o    = idx_q;
    case (state_q)
      lehdp_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          mem_ctrl_o.clear = req_i.start_req;
          mem_ctrl_o.rd_en = 1'b1;
          raddr_o          = top;
          n_d              = n_eff;
          k_d              = req_i.digit;
          pos_d            = '0;
          step_d           = top;
          pend_d           = 1'b1;
          state_d          = lehdp_pkg::ST_DESC;
        end
      end
      lehdp_pkg::ST_DESC: begin
        pos_d  = pos_nx;
        k_d    = k_nx;
        step_d = step_nx;
        if (step_nx == '0) begin
          if (elem > {1'b0, n_q}) begin
            res_d   = lehdp_pkg::ElemW'({1'b0, n_q} + OneW);
            err_d   = 1'b1;
            state_d = lehdp_pkg::ST_DONE;
          end else begin
            res_d            = lehdp_pkg::ElemW'(elem);
            err_d            = 1'b0;
            idx_d            = IW'(elem);
            mem_ctrl_o.rd_en = 1'b1;
            raddr_o          = IW'(elem);
            state_d          = lehdp_pkg::ST_REM;
          end
        end else begin
          pend_d           = probe_ok;
          mem_ctrl_o.rd_en = probe_ok;
          raddr_o          = IW'(probe);
        end
      end
      lehdp_pkg::ST_REM: begin
        mem_ctrl_o.wr_en = 1'b1;
        if (idx_ok) begin
          mem_ctrl_o.rd_en = 1'b1;
          raddr_o          = IW'(idx_nx);
          idx_d            = IW'(idx_nx);
        end else begin
          state_d = lehdp_pkg::ST_DONE;
        end
      end
      lehdp_pkg::ST_DONE: begin
        if (load) begin
          state_d = lehdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lehdp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lehdp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    err_q  <= err_d;
    if (load) begin
      out_elem_q <= res_q;
      out_err_q  <= err_q;
    end
  end

  assign req_i.ready        = (state_q == lehdp_pkg::ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.element      = out_elem_q;
  assign rsp_o.out_of_range = out_err_q;

endmodule

// ----- design/lehmer_digit_to_permutation.sv -----
// Top level of the Lehmer digit to permutation decoder.
//
// Each request on req_i carries one Lehmer digit and a start flag. The block
// answers every request with exactly one response on rsp_o: the selected
// one-based element, or clamped element_count+1 with out_of_range set when
// the digit is not below the number of unused elements. A start flag makes all
// elements unused again before its digit is decoded.
// The element_count register is written through cfg_we_i and cfg_wdata_i;
// the user must write it only while no request is in flight, which the block
// does not enforce; values are clamped to 1..MAX_ELEMENTS. The descent walks
// floor(log2(n)) + 1 tree levels and the removal path is at most as long.
// The descent reads at most one entry of the single count memory per level,
// and the removal walk writes one entry per step while reading the next.
// Requests are taken one at a time; a new request is taken once the previous
// response sits in the output register, even while the receiver stalls it.
// After reset all elements are unused and element_count is 256; no clearing
// pass is needed.
module lehmer_digit_to_permutation #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lehdp_pkg::ElemCntW-1:0]    cfg_wdata_i,
  lehdp_req_if.sink                         req_i,
  lehdp_rsp_if.source                       rsp_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1);

  logic [lehdp_pkg::ElemCntW-1:0] elem_count_q;
  lehdp_pkg::mem_ctrl_t           mem_ctrl;
  logic [IW-1:0]                  raddr;
  logic [IW-1:0]                  waddr;
  logic [IW:0]                    wdata;
  logic [IW:0]                    rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= lehdp_pkg::ElemCountReset;
    end else if (cfg_we_i) begin
      elem_count_q <= cfg_wdata_i;
    end
  end

  lehdp_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_count_i (elem_count_q),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .mem_ctrl_o   (mem_ctrl),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rdata_i      (rdata)
  );

  lehdp_cnt_mem #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the Lehmer digit to permutation decoder.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxElements  = 256;
  localparam int unsigned ItemTarget   = 1150;
  localparam int unsigned SettleCycles = 25;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned PrintLimit   = 40;

  typedef struct packed {
    logic [lehdp_pkg::ElemW-1:0] element;
    logic                        out_of_range;
  } decoded_elem_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we;
  logic [lehdp_pkg::ElemCntW-1:0] cfg_wdata;

  lehdp_req_if req_if ();
  lehdp_rsp_if rsp_if ();

  lehmer_digit_to_permutation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  bit [31:0]                      unused_counts [1:MaxElements];
  logic [lehdp_pkg::ElemCntW-1:0] element_count_reg;
  decoded_elem_t                  pending_elements [$];
  int unsigned                    mismatches;
  int unsigned                    digits_sent;
  int unsigned                    quiet_cycles;
  int unsigned                    stall_left;
  bit                             idling_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restore_counts();
    for (int unsigned i = 1; i <= MaxElements; i++) begin
      unused_counts[i] = i & (~i + 1);
    end
  endfunction

  function automatic int unsigned effective_count();
    int unsigned n;
    n = element_count_reg;
    if (n < 1) n = 1;
    if (n > MaxElements) n = MaxElements;
    return n;
  endfunction

  function automatic decoded_elem_t decode_lehmer_digit(
      input logic [lehdp_pkg::DigitW-1:0] digit, input logic start);
    decoded_elem_t res;
    int unsigned   n;
    int unsigned   rank;
    int unsigned   pos;
    int unsigned   stride;
    int unsigned   nxt;
    int unsigned   idx;
    n = effective_count();
    rank = digit;
    pos = 0;
    if (start) restore_counts();
    stride = 1;
    while (stride <= (n >> 1)) stride = stride << 1;
    while (stride > 0) begin
      nxt = pos + stride;
      if (nxt <= n && unused_counts[nxt] <= rank) begin
        rank = rank - unused_counts[nxt];
        pos = nxt;
      end
      stride = stride >> 1;
    end
    if (pos + 1 > n) begin
      res.element = lehdp_pkg::ElemW'(n + 1);
      res.out_of_range = 1'b1;
    end else begin
      idx = pos + 1;
      while (idx <= n) begin
        unused_counts[idx] = unused_counts[idx] - 1;
        idx = idx + (idx & (~idx + 1));
      end
      res.element = lehdp_pkg::ElemW'(pos + 1);
      res.out_of_range = 1'b0;
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PrintLimit) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_digit(input logic [lehdp_pkg::DigitW-1:0] digit, input logic start,
                            output decoded_elem_t predicted);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.digit     <= digit;
    req_if.start_req <= start;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = decode_lehmer_digit(digit, start);
    pending_elements.push_back(predicted);
    digits_sent++;
  endtask

  task automatic send(input logic [lehdp_pkg::DigitW-1:0] digit, input logic start);
    decoded_elem_t predicted;
    send_digit(digit, start, predicted);
  endtask

  task automatic wait_until_idle();
    req_if.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_element_count(input logic [lehdp_pkg::ElemCntW-1:0] value);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    element_count_reg = value;
  endtask

  // Sends one decode sequence for the current count; broken sequences mix in noise.
  task automatic run_sequence(input bit broken);
    decoded_elem_t res;
    int unsigned   n;
    int unsigned   remaining;
    int unsigned   hi;
    logic          start;
    n = effective_count();
    remaining = n;
    for (int unsigned i = 0; i < n; i++) begin
      if (broken && $urandom_range(0, 7) == 0) begin
        start = $urandom_range(0, 1);
        send_digit(lehdp_pkg::DigitW'($urandom_range(0, 255)), start, res);
      end else begin
        start = (i == 0) && !(broken && $urandom_range(0, 3) == 0);
        if (start) remaining = n;
        hi = (remaining == 0) ? 0 : ((remaining > 256) ? 255 : remaining - 1);
        send_digit(lehdp_pkg::DigitW'($urandom_range(0, hi)), start, res);
      end
      if (start) remaining = n;
      if (!res.out_of_range && remaining != 0) remaining--;
    end
    if ($urandom_range(0, 2) == 0) begin
      send(lehdp_pkg::DigitW'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_directed();
    idling_on = 1'b0;
    send(8'd255, 1'b1);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    send(8'd253, 1'b0);
    send(8'd0, 1'b1);
    write_element_count(9'd1);
    send(8'd0, 1'b1);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    write_element_count(9'd0);
    send(8'd0, 1'b1);
    send(8'd1, 1'b0);
    write_element_count(9'd511);
    send(8'd255, 1'b1);
    send(8'd128, 1'b0);
    write_element_count(9'd257);
    send(8'd0, 1'b1);
    write_element_count(9'd2);
    send(8'd1, 1'b1);
    send(8'd0, 1'b0);
    send(8'd0, 1'b0);
    write_element_count(9'd8);
    send(8'd0, 1'b1);
    send(8'd3, 1'b0);
    write_element_count(9'd16);
    send(8'd10, 1'b0);
    send(8'd15, 1'b0);
    send(8'd0, 1'b0);
  endtask

  task automatic test_count_change_midsequence();
    for (int i = 0; i < 4; i++) begin
      idling_on = $urandom_range(0, 1);
      write_element_count(lehdp_pkg::ElemCntW'($urandom_range(1, 20)));
      for (int j = 0; j < 6; j++) begin
        send(lehdp_pkg::DigitW'($urandom_range(0, 7)), j == 0);
      end
      write_element_count(lehdp_pkg::ElemCntW'($urandom_range(1, 40)));
      for (int j = 0; j < 8; j++) begin
        send(lehdp_pkg::DigitW'($urandom_range(0, 31)), 1'b0);
      end
    end
  endtask

  task automatic test_random_permutations();
    int unsigned                    big_runs;
    int unsigned                    r;
    logic [lehdp_pkg::ElemCntW-1:0] value;
    big_runs = 0;
    while (digits_sent < ItemTarget) begin
      r = $urandom_range(0, 19);
      if (r == 0 && big_runs < 2 && digits_sent + 300 < ItemTarget) begin
        value = ($urandom_range(0, 1) != 0) ? 9'd256 :
                lehdp_pkg::ElemCntW'($urandom_range(257, 511));
        big_runs++;
      end else if (r < 3) begin
        value = lehdp_pkg::ElemCntW'($urandom_range(0, 2));
      end else begin
        value = lehdp_pkg::ElemCntW'($urandom_range(3, 40));
      end
      write_element_count(value);
      idling_on = $urandom_range(0, 3) != 0;
      run_sequence($urandom_range(0, 4) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decoded_elem_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_elements.size() == 0) begin
        report_mismatch("response with no request pending", rsp_if.element, 0);
      end else begin
        want = pending_elements.pop_front();
        if (rsp_if.element !== want.element) begin
          report_mismatch("element", rsp_if.element, want.element);
        end
        if (rsp_if.out_of_range !== want.out_of_range) begin
          report_mismatch("out_of_range", rsp_if.out_of_range, want.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.digit     <= '0;
    req_if.start_req <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    mismatches   = 0;
    digits_sent  = 0;
    idling_on    = 1'b0;
    element_count_reg = lehdp_pkg::ElemCountReset;
    restore_counts();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_count_change_midsequence();
    test_random_permutations();

    wait_until_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lehdp_pkg.sv
design/lehdp_if.sv
design/lehdp_cnt_mem.sv
design/lehdp_ctrl.sv
design/lehmer_digit_to_permutation.sv
dv/testbench.sv
